### hw/rtl/hc_transpose_read_address_gen_defines.svh
// Assertion macros used by the transpose read-address generator datapath.
`ifndef HC_TRANSPOSE_READ_ADDRESS_GEN_DEFINES_SVH
`define HC_TRANSPOSE_READ_ADDRESS_GEN_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define HC_TP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also applies during reset.
`define HC_TP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/hc_tp_pkg.sv
`timescale 1ns / 1ps
package hc_tp_pkg;

    localparam int LINES       = 64;
    localparam int LINE_W      = 6;
    localparam int LINE_BYTES  = 32;
    localparam int PAGE_SHIFT  = 11;
    localparam int PAGE_OFF_W  = 11;
    localparam int PAGE_IDX_W  = 21;
    localparam int DIV_W       = 24;   // widest divisor: chan_tiles * width_tiles
    localparam int OPND_W      = 32;
    localparam int CNT_W       = 11;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 3;

    localparam logic [REG_IDX_W-1:0] REG_WIDTH_TILES = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHAN_TILES  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT_ROWS = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PLANE_ELEMS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BATCH_ELEMS = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_START_TILE  = 3'd5;

    typedef struct packed {
        logic [11:0] width_tiles;
        logic [11:0] chan_tiles;
        logic [15:0] height_rows;
        logic [30:0] plane_elems;
        logic [30:0] batch_elems;
        logic [31:0] start_tile;
    } cfg_t;

    // reposition jobs, run in this order on the shared divide/multiply unit
    typedef enum logic [2:0] {
        JOB_TILES = 3'd0,   // start_tile / (CT*WT)
        JOB_H     = 3'd1,   // quotient % H -> row index
        JOB_W     = 3'd2,   // start_tile / WT, remainder -> col tile
        JOB_C     = 3'd3,   // quotient % CT -> chan tile
        JOB_CHOFF = 3'd4,   // chan tile * channel stride
        JOB_B     = 3'd5,   // start_tile / (batch_elems >> 10)
        JOB_BOFF  = 3'd6    // quotient * batch stride
    } job_t;

    typedef enum logic {
        AR_DIV = 1'b0,
        AR_MUL = 1'b1
    } ar_op_t;

    typedef struct packed {
        logic capture;
        logic ar_go;
        logic ar_store;
        job_t job;
        logic prep_a;
        logic prep_b;
        logic emit;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic ar_done;
        logic out_free;
        logic last_line;
    } dp_status_t;

endpackage

### hw/rtl/hc_tp_arith.sv
`timescale 1ns / 1ps
module hc_tp_arith #(
    parameter int ADDR_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start_i,
    input  hc_tp_pkg::ar_op_t             op_i,
    input  logic [hc_tp_pkg::OPND_W-1:0]  opnd_i,
    input  logic [hc_tp_pkg::DIV_W-1:0]   divisor_i,
    input  logic [ADDR_BITS-1:0]          mcand_i,
    output logic                          busy_o,
    output logic                          done_o,
    output logic [hc_tp_pkg::OPND_W-1:0]  quo_o,
    output logic [hc_tp_pkg::DIV_W-1:0]   rem_o,
    output logic [ADDR_BITS-1:0]          prod_o
);

    localparam int OW     = hc_tp_pkg::OPND_W;
    localparam int DW     = hc_tp_pkg::DIV_W;
    localparam int STEP_W = $clog2(OW);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    hc_tp_pkg::ar_op_t op_reg;
    logic              zero_reg;
    logic [OW-1:0]     q_reg;
    logic [DW-1:0]     r_reg;
    logic [DW-1:0]     dvsr_reg;
    logic [ADDR_BITS-1:0] mcand_reg;
    logic [ADDR_BITS-1:0] acc_reg;

    logic [DW:0]          shifted;
    logic                 ge;
    logic [DW-1:0]        r_next;
    logic [ADDR_BITS-1:0] acc_next;

    // restoring divide one quotient bit per step; MSB-first shift-add multiply
    always_comb begin
        shifted  = {r_reg, q_reg[OW-1]};
        ge       = (shifted >= {1'b0, dvsr_reg});
        r_next   = ge ? DW'(shifted - {1'b0, dvsr_reg}) : shifted[DW-1:0];
        acc_next = {acc_reg[ADDR_BITS-2:0], 1'b0} + (q_reg[OW-1] ? mcand_reg : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start_i) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(OW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_i) begin
            op_reg    <= op_i;
            zero_reg  <= (divisor_i == '0);
            q_reg     <= opnd_i;
            r_reg     <= '0;
            dvsr_reg  <= divisor_i;
            mcand_reg <= mcand_i;
            acc_reg   <= '0;
        end else if (busy_reg) begin
            if (op_reg == hc_tp_pkg::AR_DIV) begin
                q_reg <= {q_reg[OW-2:0], ge};
                r_reg <= r_next;
            end else begin
                q_reg   <= {q_reg[OW-2:0], 1'b0};
                acc_reg <= acc_next;
            end
        end
    end

    // division by zero reads back as zero quotient and remainder
    assign busy_o = busy_reg;
    assign done_o = done_reg;
    assign quo_o  = zero_reg ? '0 : q_reg;
    assign rem_o  = zero_reg ? '0 : r_reg;
    assign prod_o = acc_reg;

endmodule

### hw/rtl/hc_tp_datapath.sv
`timescale 1ns / 1ps
`include "hc_transpose_read_address_gen_defines.svh"
module hc_tp_datapath #(
    parameter int ADDR_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hc_tp_pkg::cfg_t       cfg_i,
    input  logic [31:0]           dest_base_i,
    input  hc_tp_pkg::dp_cmd_t    cmd_i,
    output hc_tp_pkg::dp_status_t st_o,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,
    output logic                  m_tlast
);

    localparam int AW    = ADDR_BITS;
    localparam int OW    = hc_tp_pkg::OPND_W;
    localparam int DW    = hc_tp_pkg::DIV_W;
    localparam int CW    = hc_tp_pkg::CNT_W;
    localparam int LW    = hc_tp_pkg::LINE_W;
    localparam int EXT_W = (ADDR_BITS > 32) ? ADDR_BITS : 32;

    // architectural tile position
    logic [15:0]   row_index_reg;
    logic [CW-1:0] col_tile_reg;
    logic [CW-1:0] chan_tile_reg;
    logic [AW-1:0] row_tile_base_reg;
    logic [AW-1:0] chan_offset_reg;
    logic [AW-1:0] batch_offset_reg;

    logic [OW-1:0] opnd_reg;
    logic [AW-1:0] sum_reg;
    logic [AW-1:0] tile_reg;
    logic [AW-1:0] base_reg;
    logic [AW-1:0] run_reg;
    logic [AW-1:0] run_next;
    logic [31:0]   dest_cnt_reg;
    logic [LW-1:0] line_reg;
    logic          m_tvalid_reg;
    logic [63:0]   m_tdata_reg;
    logic          m_tlast_reg;

    logic [AW-1:0] plane2, plane2_x16, plane2_x32, batch2;
    logic [23:0]   tiles_prod;
    logic [22:0]   rtb_prod;
    logic [10:0]   h_off;
    logic [1:0]    nsub;
    logic [AW-1:0] quad_off;
    logic [EXT_W-1:0] src_ext;
    logic          last_line;
    logic          out_load;
    logic [11:0]   col_inc;
    logic [11:0]   chan_inc;
    logic [16:0]   row_inc;

    hc_tp_pkg::ar_op_t ar_op;
    logic [OW-1:0] ar_opnd;
    logic [DW-1:0] ar_divisor;
    logic [AW-1:0] ar_mcand;
    logic          ar_busy;
    logic          ar_done;
    logic [OW-1:0] ar_quo;
    logic [DW-1:0] ar_rem;
    logic [AW-1:0] ar_prod;

    always_comb begin
        plane2     = AW'({cfg_i.plane_elems, 1'b0});
        batch2     = AW'({cfg_i.batch_elems, 1'b0});
        plane2_x16 = AW'({plane2, 4'b0});
        plane2_x32 = AW'({plane2, 5'b0});
        tiles_prod = 24'(cfg_i.width_tiles) * 24'(cfg_i.chan_tiles);
        rtb_prod   = 23'(ar_rem[15:5]) * 23'(cfg_i.width_tiles);
        // (h%32 >> 4) << 10 and (h%16) << 5 share no bits
        h_off      = {row_index_reg[4], 1'b0, row_index_reg[3:0], 5'b0};
        last_line  = (line_reg == LW'(hc_tp_pkg::LINES - 1));
        out_load   = cmd_i.emit;
        src_ext    = EXT_W'(run_reg);
        col_inc    = {1'b0, col_tile_reg} + 12'd1;
        chan_inc   = {1'b0, chan_tile_reg} + 12'd1;
        row_inc    = {1'b0, row_index_reg} + 17'd1;
    end

    // next quadrant: 0 1 / 2 3, right half +512 bytes, lower half +16 channels
    always_comb begin
        nsub     = line_reg[LW-1:LW-2] + 2'd1;
        quad_off = (nsub[1] ? plane2_x16 : '0) + (nsub[0] ? AW'(512) : '0);
        if (line_reg[3:0] != 4'hF) begin
            run_next = run_reg + plane2;
        end else begin
            run_next = base_reg + quad_off;
        end
    end

    always_comb begin
        ar_op      = hc_tp_pkg::AR_DIV;
        ar_opnd    = '0;
        ar_divisor = '0;
        ar_mcand   = '0;
        case (cmd_i.job)
            hc_tp_pkg::JOB_TILES: begin
                ar_opnd    = cfg_i.start_tile;
                ar_divisor = tiles_prod;
            end
            hc_tp_pkg::JOB_H: begin
                ar_opnd    = opnd_reg;
                ar_divisor = DW'(cfg_i.height_rows);
            end
            hc_tp_pkg::JOB_W: begin
                ar_opnd    = cfg_i.start_tile;
                ar_divisor = DW'(cfg_i.width_tiles);
            end
            hc_tp_pkg::JOB_C: begin
                ar_opnd    = opnd_reg;
                ar_divisor = DW'(cfg_i.chan_tiles);
            end
            hc_tp_pkg::JOB_CHOFF: begin
                ar_op    = hc_tp_pkg::AR_MUL;
                ar_opnd  = OW'(chan_tile_reg);
                ar_mcand = plane2_x32;
            end
            hc_tp_pkg::JOB_B: begin
                ar_opnd    = cfg_i.start_tile;
                ar_divisor = DW'(cfg_i.batch_elems[30:10]);
            end
            hc_tp_pkg::JOB_BOFF: begin
                ar_op    = hc_tp_pkg::AR_MUL;
                ar_opnd  = opnd_reg;
                ar_mcand = batch2;
            end
            default: begin
                ar_op = hc_tp_pkg::AR_DIV;
            end
        endcase
    end

    hc_tp_arith #(
        .ADDR_BITS (ADDR_BITS)
    ) u_arith (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start_i   (cmd_i.ar_go),
        .op_i      (ar_op),
        .opnd_i    (ar_opnd),
        .divisor_i (ar_divisor),
        .mcand_i   (ar_mcand),
        .busy_o    (ar_busy),
        .done_o    (ar_done),
        .quo_o     (ar_quo),
        .rem_o     (ar_rem),
        .prod_o    (ar_prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_index_reg     <= '0;
            col_tile_reg      <= '0;
            chan_tile_reg     <= '0;
            row_tile_base_reg <= '0;
            chan_offset_reg   <= '0;
            batch_offset_reg  <= '0;
        end else if (cmd_i.ar_store) begin
            case (cmd_i.job)
                hc_tp_pkg::JOB_H: begin
                    row_index_reg     <= ar_rem[15:0];
                    row_tile_base_reg <= AW'(rtb_prod);
                end
                hc_tp_pkg::JOB_W:     col_tile_reg     <= ar_rem[CW-1:0];
                hc_tp_pkg::JOB_C:     chan_tile_reg    <= ar_rem[CW-1:0];
                hc_tp_pkg::JOB_CHOFF: chan_offset_reg  <= ar_prod;
                hc_tp_pkg::JOB_BOFF:  batch_offset_reg <= ar_prod;
                default: begin
                end
            endcase
        end else if (cmd_i.advance) begin
            // col, then chan, then row; carry taken only on an exact match
            if (col_inc == cfg_i.width_tiles) begin
                col_tile_reg <= '0;
                if (chan_inc == cfg_i.chan_tiles) begin
                    chan_tile_reg   <= '0;
                    chan_offset_reg <= '0;
                    if (row_inc == {1'b0, cfg_i.height_rows}) begin
                        batch_offset_reg  <= batch_offset_reg + batch2;
                        row_index_reg     <= '0;
                        row_tile_base_reg <= '0;
                    end else begin
                        row_index_reg <= row_inc[15:0];
                        if (row_index_reg[4:0] == 5'd31) begin
                            row_tile_base_reg <= row_tile_base_reg + AW'(cfg_i.width_tiles);
                        end
                    end
                end else begin
                    chan_tile_reg   <= chan_inc[CW-1:0];
                    chan_offset_reg <= chan_offset_reg + plane2_x32;
                end
            end else begin
                col_tile_reg <= col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.ar_store && (cmd_i.job == hc_tp_pkg::JOB_TILES ||
                               cmd_i.job == hc_tp_pkg::JOB_W ||
                               cmd_i.job == hc_tp_pkg::JOB_B)) begin
            opnd_reg <= ar_quo;
        end
        if (cmd_i.prep_a) begin
            sum_reg  <= batch_offset_reg + chan_offset_reg;
            tile_reg <= row_tile_base_reg + AW'(col_tile_reg);
        end
        if (cmd_i.prep_b) begin
            base_reg <= sum_reg + AW'({tile_reg, 11'b0}) + AW'(h_off);
            run_reg  <= sum_reg + AW'({tile_reg, 11'b0}) + AW'(h_off);
        end else if (out_load) begin
            run_reg <= run_next;
        end
        if (cmd_i.capture) begin
            dest_cnt_reg <= dest_base_i;
        end else if (out_load) begin
            dest_cnt_reg <= dest_cnt_reg + 32'(hc_tp_pkg::LINE_BYTES);
        end
        if (out_load) begin
            m_tdata_reg <= {dest_cnt_reg, src_ext[10:0], src_ext[31:11]};
            m_tlast_reg <= last_line;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd_i.capture) begin
                line_reg <= '0;
            end else if (out_load) begin
                line_reg <= line_reg + 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign st_o.ar_done   = ar_done;
    assign st_o.out_free  = !m_tvalid_reg || m_tready;
    assign st_o.last_line = last_line;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `HC_TP_ASSERT_CLK(a_ar_no_restart, aclk, aresetn, cmd_i.ar_go |-> !ar_busy, "arith unit restarted while busy")
    `HC_TP_ASSERT_CLK(a_hold_while_stalled, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "beat changed while stalled")
    `HC_TP_ASSERT_CLK(a_capture_pending_last, aclk, aresetn, cmd_i.capture |-> !m_tvalid || m_tlast, "new tile taken with old tile beats pending")
    `HC_TP_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

### hw/rtl/hc_tp_ctrl.sv
`timescale 1ns / 1ps
module hc_tp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tuser,
    output logic                  s_tready,
    output hc_tp_pkg::dp_cmd_t    cmd_o,
    input  hc_tp_pkg::dp_status_t st_i
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LAUNCH = 6'b000010,
        S_WAIT   = 6'b000100,
        S_PREP_A = 6'b001000,
        S_PREP_B = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    hc_tp_pkg::job_t   job_reg, job_next;

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        cmd_o      = '0;
        cmd_o.job  = job_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_o.capture = 1'b1;
                    if (s_tuser) begin
                        job_next   = hc_tp_pkg::JOB_TILES;
                        state_next = S_LAUNCH;
                    end else begin
                        state_next = S_PREP_A;
                    end
                end
            end
            S_LAUNCH: begin
                cmd_o.ar_go = 1'b1;
                state_next  = S_WAIT;
            end
            S_WAIT: begin
                if (st_i.ar_done) begin
                    cmd_o.ar_store = 1'b1;
                    if (job_reg == hc_tp_pkg::JOB_BOFF) begin
                        state_next = S_PREP_A;
                    end else begin
                        job_next   = hc_tp_pkg::job_t'(job_reg + 3'd1);
                        state_next = S_LAUNCH;
                    end
                end
            end
            S_PREP_A: begin
                cmd_o.prep_a = 1'b1;
                state_next   = S_PREP_B;
            end
            S_PREP_B: begin
                cmd_o.prep_b = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT: begin
                if (st_i.out_free) begin
                    cmd_o.emit = 1'b1;
                    if (st_i.last_line) begin
                        cmd_o.advance = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            job_reg   <= hc_tp_pkg::JOB_TILES;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

### hw/rtl/hc_transpose_read_address_gen.sv
`timescale 1ns / 1ps
// Each accepted tile request gives 64 line-read beats, one per cycle while m_tready is high.
// Next-tile request: accept, base-address adds in PREP_A and PREP_B, then 64 line beats
// from the output register; no new request is taken until the last beat is loaded.
// Reposition request first runs seven jobs in turn on the shared 32-step divide/multiply unit.
// aresetn (synchronous, active low) restores register defaults and zeroes counters and offsets.
module hc_transpose_read_address_gen #(
    parameter int ADDR_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hc_tp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [hc_tp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [hc_tp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [31:0] dest_base
    input  logic                              s_tuser,   // [0] cmd
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [63:0]                       m_tdata,   // [20:0] page_index,
                                                         // [31:21] page_offset,
                                                         // [63:32] dest_addr
    output logic                              m_tlast    // last line of the tile
);

    localparam int DWD = hc_tp_pkg::APB_DATA_W;

    hc_tp_pkg::cfg_t       cfg_reg;
    hc_tp_pkg::dp_cmd_t    dp_cmd;
    hc_tp_pkg::dp_status_t dp_st;

    logic [hc_tp_pkg::REG_IDX_W-1:0] reg_idx;
    logic                            wr_en;

    assign reg_idx = paddr[hc_tp_pkg::APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width_tiles <= 12'd1;
            cfg_reg.chan_tiles  <= 12'd1;
            cfg_reg.height_rows <= 16'd32;
            cfg_reg.plane_elems <= 31'd1024;
            cfg_reg.batch_elems <= 31'd1024;
            cfg_reg.start_tile  <= 32'd0;
        end else if (wr_en) begin
            unique case (reg_idx)
                hc_tp_pkg::REG_WIDTH_TILES: cfg_reg.width_tiles <= pwdata[11:0];
                hc_tp_pkg::REG_CHAN_TILES:  cfg_reg.chan_tiles  <= pwdata[11:0];
                hc_tp_pkg::REG_HEIGHT_ROWS: cfg_reg.height_rows <= pwdata[15:0];
                hc_tp_pkg::REG_PLANE_ELEMS: cfg_reg.plane_elems <= pwdata[30:0];
                hc_tp_pkg::REG_BATCH_ELEMS: cfg_reg.batch_elems <= pwdata[30:0];
                hc_tp_pkg::REG_START_TILE:  cfg_reg.start_tile  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            hc_tp_pkg::REG_WIDTH_TILES: prdata = DWD'(cfg_reg.width_tiles);
            hc_tp_pkg::REG_CHAN_TILES:  prdata = DWD'(cfg_reg.chan_tiles);
            hc_tp_pkg::REG_HEIGHT_ROWS: prdata = DWD'(cfg_reg.height_rows);
            hc_tp_pkg::REG_PLANE_ELEMS: prdata = DWD'(cfg_reg.plane_elems);
            hc_tp_pkg::REG_BATCH_ELEMS: prdata = DWD'(cfg_reg.batch_elems);
            hc_tp_pkg::REG_START_TILE:  prdata = cfg_reg.start_tile;
            default:                    prdata = '0;
        endcase
    end

    hc_tp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cmd_o    (dp_cmd),
        .st_i     (dp_st)
    );

    hc_tp_datapath #(
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_i       (cfg_reg),
        .dest_base_i (s_tdata),
        .cmd_i       (dp_cmd),
        .st_o        (dp_st),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

### tb/sv/hc_transpose_read_address_gen_tb.sv
`timescale 1ns / 1ps

class tile_read_scoreboard;
    // register copies
    bit [11:0] width_tiles;
    bit [11:0] chan_tiles;
    bit [15:0] height_rows;
    bit [30:0] plane_elems;
    bit [30:0] batch_elems;
    bit [31:0] start_tile;
    // walk position
    bit [15:0] row_index;
    bit [10:0] col_tile;
    bit [10:0] chan_tile;
    bit [31:0] row_tile_base;
    bit [31:0] chan_offset;
    bit [31:0] batch_offset;
    // {last, dest_addr, page_offset, page_index}
    logic [64:0] pending_reads[$];
    int mismatches;

    function new();
        width_tiles   = 12'd1;
        chan_tiles    = 12'd1;
        height_rows   = 16'd32;
        plane_elems   = 31'd1024;
        batch_elems   = 31'd1024;
        start_tile    = '0;
        row_index     = '0;
        col_tile      = '0;
        chan_tile     = '0;
        row_tile_base = '0;
        chan_offset   = '0;
        batch_offset  = '0;
        mismatches    = 0;
    endfunction

    function bit [63:0] quot_or_zero(bit [63:0] a, bit [63:0] b);
        return (b == 0) ? 64'd0 : a / b;
    endfunction

    function bit [63:0] rem_or_zero(bit [63:0] a, bit [63:0] b);
        return (b == 0) ? 64'd0 : a % b;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
        case (idx)
            hc_tp_pkg::REG_WIDTH_TILES: width_tiles = value[11:0];
            hc_tp_pkg::REG_CHAN_TILES:  chan_tiles  = value[11:0];
            hc_tp_pkg::REG_HEIGHT_ROWS: height_rows = value[15:0];
            hc_tp_pkg::REG_PLANE_ELEMS: plane_elems = value[30:0];
            hc_tp_pkg::REG_BATCH_ELEMS: batch_elems = value[30:0];
            hc_tp_pkg::REG_START_TILE:  start_tile  = value;
            default: ;
        endcase
    endfunction

    function void seek_start_tile();
        bit [63:0] tmp;
        bit [31:0] plane2;
        plane2 = {plane_elems, 1'b0};
        tmp = rem_or_zero(quot_or_zero(64'(start_tile), 64'(chan_tiles) * 64'(width_tiles)),
                          64'(height_rows));
        row_index = tmp[15:0];
        tmp = 64'(row_index >> 5) * 64'(width_tiles);
        row_tile_base = tmp[31:0];
        tmp = rem_or_zero(quot_or_zero(64'(start_tile), 64'(width_tiles)), 64'(chan_tiles));
        chan_tile = tmp[10:0];
        chan_offset = 32'(chan_tile) * (plane2 << 5);
        tmp = rem_or_zero(64'(start_tile), 64'(width_tiles));
        col_tile = tmp[10:0];
        tmp = quot_or_zero(64'(start_tile), 64'(batch_elems >> 10)) * 64'({batch_elems, 1'b0});
        batch_offset = tmp[31:0];
    endfunction

    // Computes the 64 line reads of one tile request, then steps the walk.
    function void note_request(logic cmd, logic [31:0] dest_base);
        bit [31:0] plane2;
        bit [31:0] tile_off;
        bit [31:0] src;
        bit [31:0] csub;
        bit [31:0] sub_off;
        bit [31:0] dest;
        bit [4:0]  h32;
        bit [1:0]  sub;
        bit [3:0]  c16;
        if (cmd)
            seek_start_tile();
        plane2   = {plane_elems, 1'b0};
        h32      = row_index[4:0];
        tile_off = (row_tile_base + 32'(col_tile)) << 11;
        for (int line = 0; line < 64; line++) begin
            sub     = line[5:4];
            c16     = line[3:0];
            csub    = sub[1] ? (plane2 << 4) : 32'd0;
            sub_off = (32'(sub[0]) << 9) + (32'(h32[4]) << 10);
            src     = chan_offset + csub + 32'(c16) * plane2 + tile_off + sub_off
                      + (32'(h32[3:0]) << 5);
            src     = batch_offset + src;
            dest    = dest_base + 32'(line) * 32'd32;
            pending_reads.push_back({line == 63, dest, src[10:0], src[31:11]});
        end

        // col first, then channel, then row; batch step after the last row
        if (32'(col_tile) + 32'd1 == 32'(width_tiles)) begin
            col_tile = '0;
            chan_offset = chan_offset + (plane2 << 5);
            if (32'(chan_tile) + 32'd1 == 32'(chan_tiles)) begin
                chan_tile   = '0;
                chan_offset = '0;
                if (32'(row_index) + 32'd1 == 32'(height_rows)) begin
                    batch_offset  = batch_offset + {batch_elems, 1'b0};
                    row_index     = '0;
                    row_tile_base = '0;
                end else begin
                    row_index = row_index + 16'd1;
                    if (h32 == 5'd31)
                        row_tile_base = row_tile_base + 32'(width_tiles);
                end
            end else begin
                chan_tile = chan_tile + 11'd1;
            end
        end else begin
            col_tile = col_tile + 11'd1;
        end
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t ERROR %s: got %h, want %h", $realtime, field, got, want);
        mismatches++;
    endtask

    task check_read(logic [63:0] data, logic last_flag);
        logic [64:0] want;
        if (pending_reads.size() == 0) begin
            report_mismatch("beat with no read pending", data[31:0], '0);
            return;
        end
        want = pending_reads.pop_front();
        if (data[20:0] !== want[20:0])
            report_mismatch("page_index", 32'(data[20:0]), 32'(want[20:0]));
        if (data[31:21] !== want[31:21])
            report_mismatch("page_offset", 32'(data[31:21]), 32'(want[31:21]));
        if (data[63:32] !== want[63:32])
            report_mismatch("dest_addr", data[63:32], want[63:32]);
        if (last_flag !== want[64])
            report_mismatch("last", 32'(last_flag), 32'(want[64]));
    endtask
endclass

module hc_transpose_read_address_gen_tb;

    localparam int STALL_LIMIT = 2000;
    localparam logic [hc_tp_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd6;   // no register behind it

    logic                             aclk;
    logic                             aresetn;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [hc_tp_pkg::APB_ADDR_W-1:0] paddr;
    logic [hc_tp_pkg::APB_DATA_W-1:0] pwdata;
    logic [hc_tp_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [31:0]                      s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [63:0]                      m_tdata;
    logic                             m_tlast;

    tile_read_scoreboard sb = new();
    bit idle_on = 1'b1;
    int quiet_cycles = 0;

    hc_transpose_read_address_gen dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // psel stays up between back-to-back writes; program_config drops it
    task automatic apb_write(logic [hc_tp_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, value);
    endtask

    task automatic program_config(logic [31:0] wt, logic [31:0] ct, logic [31:0] h,
                                  logic [31:0] plane, logic [31:0] batch,
                                  logic [31:0] start);
        apb_write(hc_tp_pkg::REG_WIDTH_TILES, wt);
        apb_write(hc_tp_pkg::REG_CHAN_TILES, ct);
        apb_write(hc_tp_pkg::REG_HEIGHT_ROWS, h);
        apb_write(hc_tp_pkg::REG_PLANE_ELEMS, plane);
        apb_write(hc_tp_pkg::REG_BATCH_ELEMS, batch);
        apb_write(hc_tp_pkg::REG_START_TILE, start);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // valid is left high after a beat so the next request can follow directly
    task automatic send_request(logic cmd, logic [31:0] dest_base);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= dest_base;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, dest_base);
    endtask

    task automatic drain_reads();
        s_tvalid <= 1'b0;
        while (sb.pending_reads.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic random_config();
        logic [31:0] wt, ct, h, plane, batch, start;
        wt    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 4);
        ct    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 4);
        h     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                            : 32 * $urandom_range(1, 3);
        plane = $urandom_range(0, 1) ? $urandom_range(1024, 32'h7FFF_FFFF)
                                     : 1024 * $urandom_range(1, 64);
        batch = $urandom_range(0, 1) ? $urandom_range(1024, 32'h7FFF_FFFF)
                                     : 1024 * $urandom_range(1, 64);
        start = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 511);
        program_config(wt, ct, h, plane, batch, start);
    endtask

    initial begin
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_read(m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int n;
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults straight out of reset
        send_request(1'b0, 32'h0000_0000);
        send_request(1'b1, 32'hFFFF_FFFF);
        send_request(1'b0, 32'hFFFF_FFE0);
        send_request(1'b0, 32'h8000_0000);
        drain_reads();

        // largest geometry and strides, last possible start tile
        program_config(32'd2048, 32'd2048, 32'd65535, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'hFFFF_FFFF);
        send_request(1'b1, 32'h5555_5555);
        send_request(1'b0, 32'hAAAA_AAAA);
        send_request(1'b0, 32'hFFFF_FC00);
        drain_reads();

        // every divisor zero: W masked off, C and H zero, batch stride below 1024
        program_config(32'hFFFF_F000, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'h0000_03FF,
                       32'd12345);
        @(posedge aclk);
        apb_write(REG_SPARE, 32'hDEAD_BEEF);
        psel    <= 1'b0;
        penable <= 1'b0;
        send_request(1'b1, 32'h0123_4567);
        send_request(1'b0, 32'h89AB_CDEF);
        send_request(1'b0, 32'h7FFF_FFFF);
        drain_reads();

        // start on row 31 of 33: row-tile step at 31->32, then wrap into next batch
        program_config(32'd2, 32'd2, 32'd33, 32'd1024, 32'd4096, 32'd124);
        send_request(1'b1, 32'h1000_0000);
        for (int i = 0; i < 9; i++)
            send_request(1'b0, $urandom());
        drain_reads();

        for (int phase = 0; phase < 6; phase++) begin
            idle_on = (phase != 5);
            random_config();
            n = $urandom_range(20, 32);
            send_request(1'b1, $urandom());
            for (int i = 1; i < n; i++)
                send_request($urandom_range(0, 9) == 0, $urandom());
            drain_reads();
        end

        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
